/* hw/rtl/tga_pkg.sv */
// Shared types, codes and fixed-point helpers for the tile GEMM accumulator.
package tga_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CoordW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [DataW-1:0] QOne = 32'sd65536;
  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic {
    ACT_ACCUM     = 1'b0,
    ACT_WRITEBACK = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    action_e                   action;
    logic [CoordW-1:0]         tile_row;
    logic [CoordW-1:0]         tile_col;
    logic signed [DataW-1:0]   a_value;
    logic signed [DataW-1:0]   b_value;
    logic signed [DataW-1:0]   c_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0]   result_value;
    logic [CoordW-1:0]         out_row;
    logic [CoordW-1:0]         out_col;
  } out_word_t;

  // Datapath steering from the sequencer
  typedef struct packed {
    logic mul_first;   // scale * operand, capture accumulator
    logic mul_second;  // truncated product * b
  } dp_ctrl_t;

  // Q16.16 product: drop 16 LSBs (floor), saturate to 32 bits
  function automatic logic signed [DataW-1:0] q_trunc_sat(input logic signed [2*DataW-1:0] p);
    logic signed [2*DataW-17:0] t;
    logic signed [DataW-1:0] r;
    t = p[2*DataW-1:16];
    if (!t[2*DataW-17] && (|t[2*DataW-18:DataW-1])) begin
      r = QMax;
    end else if (t[2*DataW-17] && !(&t[2*DataW-18:DataW-1])) begin
      r = QMin;
    end else begin
      r = t[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] q_add_sat(input logic signed [DataW-1:0] a,
                                                        input logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    logic signed [DataW-1:0] r;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? QMin : QMax;
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tile_gemm_accumulator_unit.sv */
// Top level: sequencer, config registers, accumulator RAM and output register.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------
//  in      | in  | in_valid_i/in_stall_o | in_word_i   (in_word_t)
//  out     | out | out_valid_o/out_stall_i| out_word_o (out_word_t)
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// An accumulate word steps through RAM read, two chained 32x32 multiplies,
// add and write-back into the RAM; a write-back word skips the second multiply.
// After reset a clearing pass writes zero to all TILE_DIM*TILE_DIM entries,
// one per cycle, with in_stall_o high; config writes are taken throughout.
// A write-back word waits in its last cycle while the output register holds
// an untaken word and out_stall_i is high.
module tile_gemm_accumulator_unit
  import tga_pkg::*;
#(
  parameter int unsigned TILE_DIM = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_word_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_word_t          out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = TILE_DIM * TILE_DIM;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL1  = 5'b00100,
    ST_MUL2  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [DataW-1:0] alpha_q, beta_q;
  logic [AddrW-1:0]        clr_cnt_q, clr_cnt_d;
  in_word_t                item_q;
  logic                    inside_q;
  logic [AddrW-1:0]        idx_q;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q;

  logic                    in_accept;
  logic                    in_inside;
  logic [AddrW-1:0]        in_idx;
  logic                    fin_go;
  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [DataW-1:0]        ram_wdata;
  logic [DataW-1:0]        ram_rdata;
  logic signed [DataW-1:0] sum;
  dp_ctrl_t                dp_ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_inside  = (int'(in_word_i.tile_row) < TILE_DIM) &&
                      (int'(in_word_i.tile_col) < TILE_DIM);
  assign in_idx     = AddrW'(int'(in_word_i.tile_row) * TILE_DIM + int'(in_word_i.tile_col));

  // last step of a write-back needs a free output slot
  assign fin_go = !(item_q.action == ACT_WRITEBACK && out_valid_q && out_stall_i);

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= QOne;
      beta_q  <= QOne;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        state_d = (item_q.action == ACT_WRITEBACK) ? ST_FIN : ST_MUL2;
      end
      ST_MUL2: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q   <= in_word_i;
      inside_q <= in_inside;
      idx_q    <= in_idx;
    end
  end

  // RAM write: clearing sweep, or read-modify-write at the end of a word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (state_q == ST_FIN && fin_go && inside_q) begin
      ram_we    = 1'b1;
      ram_wdata = (item_q.action == ACT_WRITEBACK) ? '0 : sum;
    end
  end

  tga_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  assign dp_ctrl.mul_first  = (state_q == ST_MUL1);
  assign dp_ctrl.mul_second = (state_q == ST_MUL2);

  tga_datapath u_datapath (
    .clk_i     (clk_i),
    .ctrl_i    (dp_ctrl),
    .item_i    (item_q),
    .inside_i  (inside_q),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .rd_data_i (ram_rdata),
    .sum_o     (sum)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_FIN && fin_go && item_q.action == ACT_WRITEBACK) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && fin_go && item_q.action == ACT_WRITEBACK) begin
      out_word_q.result_value <= sum;
      out_word_q.out_row      <= item_q.tile_row;
      out_word_q.out_col      <= item_q.tile_col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // assertions
  a_out_from_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN && item_q.action == ACT_WRITEBACK))
    else $error("output word without a finished write-back");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL1))
    else $error("accepted word did not start processing");

  a_mul2_accum_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL2) |-> (item_q.action == ACT_ACCUM))
    else $error("second multiply on a write-back word");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output word dropped");

endmodule

/* hw/rtl/tga_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module tga_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tga_datapath.sv */
// Shared 32x32 multiplier, truncation/saturation and accumulate adder.
module tga_datapath
  import tga_pkg::*;
(
  input  logic                    clk_i,
  input  dp_ctrl_t                ctrl_i,
  input  in_word_t                item_i,
  input  logic                    inside_i,
  input  logic signed [DataW-1:0] alpha_i,
  input  logic signed [DataW-1:0] beta_i,
  input  logic signed [DataW-1:0] rd_data_i,
  output logic signed [DataW-1:0] sum_o
);

  logic signed [2*DataW-1:0] prod_q, prod_d;
  logic signed [DataW-1:0]   acc_q, acc_d;
  logic signed [DataW-1:0]   mul_a, mul_b;
  logic signed [DataW-1:0]   prod_trunc;

  assign prod_trunc = q_trunc_sat(prod_q);

  always_comb begin
    mul_a  = prod_trunc;
    mul_b  = item_i.b_value;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctrl_i.mul_first) begin
      if (item_i.action == ACT_WRITEBACK) begin
        mul_a = beta_i;
        mul_b = item_i.c_value;
      end else begin
        mul_a = alpha_i;
        mul_b = item_i.a_value;
      end
      // out-of-tile entries read as zero
      acc_d = inside_i ? rd_data_i : '0;
    end
    if (ctrl_i.mul_first || ctrl_i.mul_second) begin
      prod_d = mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign sum_o = q_add_sat(acc_q, prod_trunc);

endmodule

/* dv/tb_tile_gemm_accumulator_unit.sv */
// Testbench for tile_gemm_accumulator_unit: Q16.16 tile update checked against a local predictor.
`timescale 1ns / 100ps

module tb_tile_gemm_accumulator_unit;
  import tga_pkg::*;

  localparam int unsigned TileDim     = 16;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400_000;

  // register indexes that map to no register
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]   cfg_data_i  = '0;

  tile_gemm_accumulator_unit #(
    .TILE_DIM(TileDim)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [DataW-1:0] alpha_now = QOne;
  logic signed [DataW-1:0] beta_now  = QOne;
  logic signed [DataW-1:0] acc_mirror [TileDim*TileDim];
  out_word_t               expected_c [$];
  out_word_t               want_c;
  int unsigned             mismatches = 0;

  // Sender pacing
  int unsigned burst_left  = 0;
  bit          steady_feed = 1'b0;
  int unsigned words_sent  = 0;

  // Receiver stall pattern
  int unsigned hold_asked = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned pat_cnt    = 0;
  int unsigned cycle_count;

  initial begin
    foreach (acc_mirror[i]) acc_mirror[i] = '0;
  end

  function automatic logic signed [DataW-1:0] fx_sat(input longint v);
    if (v > longint'(QMax)) return QMax;
    if (v < longint'(QMin)) return QMin;
    return v[DataW-1:0];
  endfunction

  // exact product, floor to Q16.16, clamp
  function automatic logic signed [DataW-1:0] fx_mul(input logic signed [DataW-1:0] x,
                                                     input logic signed [DataW-1:0] y);
    longint prod;
    prod = longint'(x) * longint'(y);
    return fx_sat(prod >>> 16);
  endfunction

  function automatic logic signed [DataW-1:0] fx_add(input logic signed [DataW-1:0] x,
                                                     input logic signed [DataW-1:0] y);
    return fx_sat(longint'(x) + longint'(y));
  endfunction

  function automatic void gemm_update(input in_word_t w);
    logic signed [DataW-1:0] term;
    out_word_t               res;
    int unsigned             slot;
    bit                      in_tile;
    in_tile = (w.tile_row < TileDim) && (w.tile_col < TileDim);
    slot    = w.tile_row * TileDim + w.tile_col;
    if (w.action == ACT_ACCUM) begin
      if (in_tile) begin
        term = fx_mul(fx_mul(alpha_now, w.a_value), w.b_value);
        acc_mirror[slot] = fx_add(acc_mirror[slot], term);
      end
    end else begin
      res.result_value = fx_add(fx_mul(beta_now, w.c_value), in_tile ? acc_mirror[slot] : '0);
      res.out_row      = w.tile_row;
      res.out_col      = w.tile_col;
      if (in_tile) acc_mirror[slot] = '0;
      expected_c.push_back(res);
    end
  endfunction

  function automatic in_word_t mk_word(input action_e act, input int unsigned row,
                                       input int unsigned col,
                                       input logic signed [DataW-1:0] a,
                                       input logic signed [DataW-1:0] b,
                                       input logic signed [DataW-1:0] c);
    in_word_t w;
    w.action   = act;
    w.tile_row = CoordW'(row);
    w.tile_col = CoordW'(col);
    w.a_value  = a;
    w.b_value  = b;
    w.c_value  = c;
    return w;
  endfunction

  // mostly small magnitudes so sums do not pin at the rails
  function automatic logic signed [DataW-1:0] rand_q();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom();
      1: v = QMax;
      2: v = QMin;
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_word(input int unsigned wb_pct);
    action_e act;
    act = ($urandom_range(0, 99) < wb_pct) ? ACT_WRITEBACK : ACT_ACCUM;
    return mk_word(act, $urandom_range(0, TileDim - 1), $urandom_range(0, TileDim - 1),
                   rand_q(), rand_q(), rand_q());
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        in_word_i  <= mk_word(ACT_WRITEBACK, $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom());
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    gemm_update(w);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA: alpha_now = val;
      CFG_BETA:  beta_now  = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // accumulates give no result, so allow the pipe to settle after the last one
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_c.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_words(input int unsigned n);
    repeat (n) send_word(rand_word(40));
  endtask

  // one output sub-tile in loop order: k outer, then rows, then columns
  task automatic gemm_pass();
    int unsigned r0, c0, rows, cols, depth;
    r0    = $urandom_range(0, TileDim - 1);
    c0    = $urandom_range(0, TileDim - 1);
    rows  = $urandom_range(1, 4);
    cols  = $urandom_range(1, 4);
    depth = $urandom_range(1, 6);
    for (int unsigned k = 0; k < depth; k++) begin
      for (int unsigned r = 0; r < rows; r++) begin
        for (int unsigned c = 0; c < cols; c++) begin
          send_word(mk_word(ACT_ACCUM, (r0 + r) % TileDim, (c0 + c) % TileDim,
                            rand_q(), rand_q(), $urandom()));
          if ($urandom_range(0, 15) == 0) send_word(rand_word(50));
        end
      end
    end
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        send_word(mk_word(ACT_WRITEBACK, (r0 + r) % TileDim, (c0 + c) % TileDim,
                          $urandom(), $urandom(), rand_q()));
      end
    end
  endtask

  // untouched entries read back as zero under the reset scales
  task automatic test_reset_state();
    send_word(mk_word(ACT_WRITEBACK, 0, 0, QMax, QMax, QOne));
    send_word(mk_word(ACT_WRITEBACK, 15, 15, QMin, QMin, QMin));
    send_word(mk_word(ACT_WRITEBACK, 9, 6, '0, '0, QMax));
    send_word(mk_word(ACT_WRITEBACK, 6, 9, $urandom(), $urandom(), -32'sd1));
    wait_idle();
  endtask

  task automatic test_corner_words();
    // product overflow both ways, then sum pinned at the negative rail
    send_word(mk_word(ACT_ACCUM, 15, 0, QMax, QMax, '0));
    send_word(mk_word(ACT_WRITEBACK, 15, 0, '0, '0, '0));
    send_word(mk_word(ACT_ACCUM, 0, 15, QMin, QMax, '0));
    send_word(mk_word(ACT_ACCUM, 0, 15, QMin, QMax, '0));
    send_word(mk_word(ACT_WRITEBACK, 0, 15, '0, '0, QMin));
    // smallest negative product floors to -1 lsb
    send_word(mk_word(ACT_ACCUM, 3, 4, -32'sd1, 32'sd1, '0));
    send_word(mk_word(ACT_WRITEBACK, 3, 4, '0, '0, '0));
    send_word(mk_word(ACT_ACCUM, 3, 4, QMin, QMin, '0));
    send_word(mk_word(ACT_WRITEBACK, 3, 4, '0, '0, QMax));
    // mixed signs cancel exactly, then the cleared entry reads zero
    send_word(mk_word(ACT_ACCUM, 7, 8, 32'sh0002_8000, -32'sh0001_8000, QMax));
    send_word(mk_word(ACT_ACCUM, 7, 8, QOne, 32'sh0003_C000, QMin));
    send_word(mk_word(ACT_WRITEBACK, 7, 8, QMax, QMin, -QOne));
    send_word(mk_word(ACT_WRITEBACK, 7, 8, QMin, QMax, QOne));
    send_word(mk_word(ACT_ACCUM, 12, 1, '0, QMax, '0));
    send_word(mk_word(ACT_ACCUM, 12, 1, QMax, '0, '0));
    send_word(mk_word(ACT_WRITEBACK, 12, 1, QMax, QMax, 32'sd1));
    wait_idle();
  endtask

  task automatic test_scale_sweep();
    logic signed [DataW-1:0] a_sc, b_sc;
    for (int unsigned phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin a_sc = QMax;    b_sc = QMin;         end
        1: begin a_sc = QMin;    b_sc = QMax;         end
        2: begin a_sc = '0;      b_sc = '0;           end
        3: begin a_sc = -QOne;   b_sc = 32'sh0000_8000; end
        4: begin a_sc = 32'sd1;  b_sc = -32'sd1;      end
        5: begin a_sc = $urandom(); b_sc = $urandom(); end
        default: begin a_sc = QOne; b_sc = QOne;      end
      endcase
      write_reg(CFG_ALPHA, a_sc);
      write_reg(CFG_BETA, b_sc);
      write_reg((phase % 2 == 0) ? CfgSpareLo : CfgSpareHi, $urandom());
      random_words(80);
      gemm_pass();
      wait_idle();
    end
  endtask

  task automatic test_gemm_stream();
    int unsigned start;
    start = words_sent;
    while (words_sent - start < 520) begin
      gemm_pass();
      if ($urandom_range(0, 2) == 0) random_words($urandom_range(1, 5));
    end
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering write-back words
  task automatic test_output_backpressure();
    steady_feed = 1'b1;
    hold_asked++;
    repeat (150) send_word(rand_word(75));
    steady_feed = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_corner_words();
    test_scale_sweep();
    test_gemm_stream();
    test_output_backpressure();
    if (mismatches == 0 && expected_c.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      pat_cnt <= pat_cnt + 1;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (pat_cnt % 5) < 2;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_c.size() == 0) begin
        $error("unexpected result word: row %0d col %0d value %0d", out_word_o.out_row,
               out_word_o.out_col, out_word_o.result_value);
        mismatches++;
      end else begin
        want_c = expected_c.pop_front();
        if (out_word_o.result_value !== want_c.result_value) begin
          $error("result_value: expected %0d, got %0d", want_c.result_value,
                 out_word_o.result_value);
          mismatches++;
        end
        if (out_word_o.out_row !== want_c.out_row) begin
          $error("out_row: expected %0d, got %0d", want_c.out_row, out_word_o.out_row);
          mismatches++;
        end
        if (out_word_o.out_col !== want_c.out_col) begin
          $error("out_col: expected %0d, got %0d", want_c.out_col, out_word_o.out_col);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tga_pkg.sv
hw/rtl/tga_ram.sv
hw/rtl/tga_datapath.sv
hw/rtl/tile_gemm_accumulator_unit.sv
dv/tb_tile_gemm_accumulator_unit.sv
